>>> sv/msr_pkg.sv
// shared types and constants of the system-exclusive reassembler
package msr_pkg;

    localparam int MSR_BUFFER_BYTES = 64;
    localparam int LEN_W            = 12;

    // framing bytes
    localparam logic [7:0] SYSEX_START = 8'hF0;
    localparam logic [7:0] SYSEX_END   = 8'hF7;

    // header bytes of the recognized reset messages
    localparam logic [7:0] MFR_ID_GS   = 8'h41;
    localparam logic [7:0] MODEL_GS    = 8'h42;
    localparam logic [7:0] CMD_DT1     = 8'h12;
    localparam logic [7:0] MFR_ID_XG   = 8'h43;
    localparam logic [7:0] MODEL_TG    = 8'h2B;
    localparam logic [7:0] MODEL_XG    = 8'h4C;
    localparam logic [7:0] UNIV_NONRT  = 8'h7E;
    localparam logic [7:0] SUB_GM      = 8'h09;
    localparam logic [7:0] DATA_MAX    = 8'h7F;
    localparam logic [7:0] GS_MODE     = 8'h40;

    typedef struct packed {
        logic             first_of_chunk;
        logic             chunk_is_split;
        logic [LEN_W-1:0] chunk_len;
        logic             has_byte;
        logic [7:0]       data_byte;
    } msr_item_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       last_of_message;
        logic       is_reset;
    } msr_result_t;

    // header byte capture request toward the reset detector
    typedef struct packed {
        logic       en;
        logic [3:0] slot;
    } msr_cap_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_LOAD,
        ST_HOLD
    } msr_state_t;

endpackage

>>> sv/midi_sysex_reassembler_unit.sv
// top level: chunk bookkeeping, buffer append and message flush sequencer
// flush: when an item completes a message the sequencer passes through
//   ST_READ and ST_LOAD before the first result is valid in ST_HOLD
// throughput: one item per cycle while appending; a flush holds the input
//   until its last byte is taken (ram read, then load, for each byte)
// reset: control state cleared asynchronously; the buffer ram is not cleared,
//   entries are only used after being written, so no clearing pass
module midi_sysex_reassembler_unit
    import msr_pkg::*;
#(
    parameter int BUFFER_BYTES = MSR_BUFFER_BYTES
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        item_valid,
    output logic        item_ready,
    input  msr_item_t   item,
    output logic        result_valid,
    input  logic        result_ready,
    output msr_result_t result
);

    localparam int FW    = $clog2(BUFFER_BYTES);
    localparam int SUM_W = LEN_W + 1;
    localparam logic [SUM_W-1:0] MAX_MSG = SUM_W'(BUFFER_BYTES - 1);

    msr_state_t state_reg;
    msr_state_t state_next;

    // chunk and buffer bookkeeping
    logic [FW-1:0]    fill_reg;
    logic [FW-1:0]    fill_next;
    logic [LEN_W-1:0] rem_reg;
    logic [LEN_W-1:0] rem_next;
    logic             drop_reg;
    logic             drop_next;
    logic [7:0]       tail_reg;      // byte at fill_reg-1, checked for F7
    logic [7:0]       tail_next;

    // flush sequencer
    logic [FW-1:0]    len_reg;
    logic [FW-1:0]    ptr_reg;
    msr_result_t      result_reg;
    msr_result_t      result_next;

    logic             accept;
    logic             flush;
    logic [FW-1:0]    flush_len;     // message length as the flush starts
    logic             take;
    logic             chunk_end;
    logic [FW-1:0]    base;
    logic [SUM_W-1:0] need;
    logic             wr_en;
    logic [FW-1:0]    wr_addr;
    logic             rd_en;
    logic [FW-1:0]    rd_addr;
    logic [7:0]       rd_data;
    logic             ptr_last;
    logic             reset_msg;
    msr_cap_t         cap;

    assign accept   = item_valid && item_ready;
    assign ptr_last = ptr_reg == (len_reg - FW'(1));

    // request processing: chunk open, byte append, end-of-chunk check
    always_comb
    begin
        fill_next = fill_reg;
        rem_next  = rem_reg;
        drop_next = drop_reg;
        tail_next = tail_reg;
        wr_en     = 1'b0;
        wr_addr   = fill_reg;
        take      = 1'b0;
        chunk_end = 1'b0;
        flush     = 1'b0;
        flush_len = fill_reg;
        base      = item.chunk_is_split ? fill_reg : FW'(1);
        need      = {1'b0, item.chunk_len} + SUM_W'(base);
        if (accept)
        begin
            if (item.first_of_chunk)
            begin
                rem_next = item.chunk_len;
                priority if (need > MAX_MSG)
                begin
                    // would overflow: empty the buffer and skip the chunk
                    fill_next = '0;
                    drop_next = 1'b1;
                end
                else if (item.chunk_is_split && fill_reg == '0)
                begin
                    // escape chunk with nothing in progress
                    drop_next = 1'b1;
                end
                else
                begin
                    drop_next = 1'b0;
                    if (!item.chunk_is_split)
                    begin
                        // entry 0 is implied F0 and never written
                        fill_next = FW'(1);
                        tail_next = SYSEX_START;
                    end
                end
                if (item.chunk_len == '0)
                begin
                    chunk_end = 1'b1;
                end
                else
                begin
                    take = item.has_byte;
                end
            end
            else
            begin
                take = item.has_byte;
            end
            if (take && rem_next != '0)
            begin
                if (!drop_next)
                begin
                    wr_en     = 1'b1;
                    wr_addr   = fill_next;
                    tail_next = item.data_byte;
                    fill_next = fill_next + FW'(1);
                end
                rem_next = rem_next - LEN_W'(1);
                if (rem_next == '0)
                begin
                    chunk_end = 1'b1;
                end
            end
            if (chunk_end && !drop_next && fill_next != '0 && tail_next == SYSEX_END)
            begin
                flush     = 1'b1;
                flush_len = fill_next;
                fill_next = '0;
            end
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (flush)
                begin
                    state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                state_next = ST_LOAD;
            end
            ST_LOAD:
            begin
                state_next = ST_HOLD;
            end
            ST_HOLD:
            begin
                if (result_ready)
                begin
                    state_next = result_reg.last_of_message ? ST_IDLE : ST_LOAD;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // state outputs: handshake, ram read, header capture
    always_comb
    begin
        item_ready   = 1'b0;
        result_valid = 1'b0;
        rd_en        = 1'b0;
        rd_addr      = ptr_reg;
        cap.en       = 1'b0;
        cap.slot     = ptr_reg[3:0];
        unique case (state_reg)
            ST_IDLE:
            begin
                item_ready = 1'b1;
            end
            ST_READ:
            begin
                rd_en = 1'b1;
            end
            ST_LOAD:
            begin
                cap.en = ptr_reg >= FW'(1) && ptr_reg <= FW'(9);
            end
            ST_HOLD:
            begin
                result_valid = 1'b1;
                // prefetch the next byte as this one leaves
                rd_en   = result_ready && !result_reg.last_of_message;
                rd_addr = ptr_reg + FW'(1);
            end
            default:
            begin
                item_ready = 1'b0;
            end
        endcase
    end

    // result word built from the ram read data
    always_comb
    begin
        result_next.out_byte        = (ptr_reg == '0) ? SYSEX_START : rd_data;
        result_next.last_of_message = ptr_last;
        result_next.is_reset        = ptr_last && reset_msg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            fill_reg  <= '0;
            rem_reg   <= '0;
            drop_reg  <= 1'b0;
            len_reg   <= '0;
            ptr_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            fill_reg  <= fill_next;
            rem_reg   <= rem_next;
            drop_reg  <= drop_next;
            if (flush)
            begin
                len_reg <= flush_len;
                ptr_reg <= '0;
            end
            else if (state_reg == ST_HOLD && result_ready && !result_reg.last_of_message)
            begin
                ptr_reg <= ptr_reg + FW'(1);
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        tail_reg <= tail_next;
        if (state_reg == ST_LOAD)
        begin
            result_reg <= result_next;
        end
    end

    assign result = result_reg;

    msr_mem #(
        .DEPTH (BUFFER_BYTES),
        .AW    (FW)
    ) u_mem (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (item.data_byte),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    msr_rstdet #(
        .NW (FW)
    ) u_rstdet (
        .clk       (clk),
        .cap       (cap),
        .cap_data  (rd_data),
        .msg_len   (len_reg),
        .reset_msg (reset_msg)
    );

    // input is held off for the whole flush
    a_no_input_in_flush: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> !item_ready)
        else $error("input taken during flush");

    // reset flag only ever on the final byte
    a_reset_on_last: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.is_reset |-> result.last_of_message)
        else $error("reset flag off the last byte");

    // every message opens with F0
    a_starts_f0: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && ptr_reg == '0 |-> result.out_byte == SYSEX_START)
        else $error("message does not start with F0");

    // the buffer never holds more than BUFFER_BYTES-1 bytes
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= FW'(BUFFER_BYTES - 1))
        else $error("fill count overflow");

    // last byte taken ends the flush
    a_flush_done: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_ready && result.last_of_message |=> item_ready)
        else $error("flush did not end after last byte");

endmodule

>>> sv/msr_mem.sv
// message buffer ram, one write port and one registered read port
module msr_mem
    import msr_pkg::*;
#(
    parameter int DEPTH = MSR_BUFFER_BYTES,
    parameter int AW    = $clog2(MSR_BUFFER_BYTES)
)
(
    input  logic          clk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [7:0]    wr_data,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    output logic [7:0]    rd_data
);

    logic [7:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

>>> sv/msr_rstdet.sv
// header byte capture and device reset message recognition
module msr_rstdet
    import msr_pkg::*;
#(
    parameter int NW = $clog2(MSR_BUFFER_BYTES)
)
(
    input  logic          clk,
    input  msr_cap_t      cap,
    input  logic [7:0]    cap_data,
    input  logic [NW-1:0] msg_len,
    output logic          reset_msg
);

    // bytes 1 to 9 of the message being flushed
    logic [7:0] hdr_reg [1:9];

    logic gs_ok;
    logic tg_ok;
    logic xg_ok;
    logic gm_ok;

    always_ff @(posedge clk)
    begin
        if (cap.en)
        begin
            hdr_reg[cap.slot] <= cap_data;
        end
    end

    always_comb
    begin
        gs_ok = hdr_reg[1] == MFR_ID_GS && hdr_reg[3] == MODEL_GS &&
                hdr_reg[4] == CMD_DT1 && msg_len == NW'(11) &&
                (((hdr_reg[5] == 8'h00) && (hdr_reg[6] == 8'h00) &&
                  (hdr_reg[7] == DATA_MAX) &&
                  (((hdr_reg[8] == 8'h00) && (hdr_reg[9] == 8'h01)) ||
                   ((hdr_reg[8] == 8'h01) && (hdr_reg[9] == 8'h00)))) ||
                 ((hdr_reg[5] == GS_MODE) && (hdr_reg[6] == 8'h00) &&
                  (hdr_reg[7] == DATA_MAX) && (hdr_reg[8] == 8'h00) &&
                  (hdr_reg[9] == MFR_ID_GS)));
        tg_ok = hdr_reg[1] == MFR_ID_XG && hdr_reg[3] == MODEL_TG &&
                msg_len == NW'(10) && hdr_reg[4] == 8'h00 &&
                hdr_reg[5] == 8'h00 && hdr_reg[6] == DATA_MAX &&
                hdr_reg[7] == 8'h00 && hdr_reg[8] == 8'h01;
        xg_ok = hdr_reg[1] == MFR_ID_XG && hdr_reg[3] == MODEL_XG &&
                msg_len == NW'(9) && hdr_reg[4] == 8'h00 &&
                hdr_reg[5] == 8'h00 &&
                (hdr_reg[6] == UNIV_NONRT || hdr_reg[6] == DATA_MAX) &&
                hdr_reg[7] == 8'h00;
        gm_ok = hdr_reg[1] == UNIV_NONRT && hdr_reg[3] == SUB_GM &&
                msg_len == NW'(6) &&
                (hdr_reg[4] == 8'h01 || hdr_reg[4] == 8'h02 ||
                 hdr_reg[4] == 8'h03);
        reset_msg = gs_ok || tg_ok || xg_ok || gm_ok;
    end

endmodule
